// ===== rtl/core/nvq_pkg.sv =====
// ----------------------------------------------------------------------------
// nvq_pkg
// Types, constants and the Q1.14 normal table for the normal vector quantizer.
// ----------------------------------------------------------------------------
package nvq_pkg;

  localparam int ROM_SIZE  = 162;
  localparam int ROM_FRAC  = 14;
  localparam int DIR_W     = 16;
  localparam int IDX_W     = 8;
  localparam int ROM_W     = 16;

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [ROM_W-1:0] rom_t;

  localparam rom_t K1000 = 16'sd16384;
  localparam rom_t K500  = 16'sd8192;
  localparam rom_t K526  = 16'sd8614;
  localparam rom_t K851  = 16'sd13937;
  localparam rom_t K443  = 16'sd7256;
  localparam rom_t K239  = 16'sd3913;
  localparam rom_t K864  = 16'sd14159;
  localparam rom_t K295  = 16'sd4837;
  localparam rom_t K955  = 16'sd15654;
  localparam rom_t K309  = 16'sd5063;
  localparam rom_t K809  = 16'sd13255;
  localparam rom_t K162  = 16'sd2662;
  localparam rom_t K263  = 16'sd4307;
  localparam rom_t K951  = 16'sd15582;
  localparam rom_t K148  = 16'sd2419;
  localparam rom_t K717  = 16'sd11740;
  localparam rom_t K682  = 16'sd11169;
  localparam rom_t K588  = 16'sd9630;
  localparam rom_t K425  = 16'sd6969;
  localparam rom_t K688  = 16'sd11275;
  localparam rom_t KZ    = 16'sd0;

  localparam rom_t NORMAL_ROM [ROM_SIZE][3] = '{
    '{-K526, KZ, K851}, '{-K443, K239, K864}, '{-K295, KZ, K955}, '{-K309, K500, K809},
    '{-K162, K263, K951}, '{KZ, KZ, K1000}, '{KZ, K851, K526}, '{-K148, K717, K682},
    '{K148, K717, K682}, '{KZ, K526, K851}, '{K309, K500, K809}, '{K526, KZ, K851},
    '{K295, KZ, K955}, '{K443, K239, K864}, '{K162, K263, K951}, '{-K682, K148, K717},
    '{-K809, K309, K500}, '{-K588, K425, K688}, '{-K851, K526, KZ}, '{-K864, K443, K239},
    '{-K717, K682, K148}, '{-K688, K588, K425}, '{-K500, K809, K309}, '{-K239, K864, K443},
    '{-K425, K688, K588}, '{-K717, K682, -K148}, '{-K500, K809, -K309}, '{-K526, K851, KZ},
    '{KZ, K851, -K526}, '{-K239, K864, -K443}, '{KZ, K955, -K295}, '{-K263, K951, -K162},
    '{KZ, K1000, KZ}, '{KZ, K955, K295}, '{-K263, K951, K162}, '{K239, K864, K443},
    '{K263, K951, K162}, '{K500, K809, K309}, '{K239, K864, -K443}, '{K263, K951, -K162},
    '{K500, K809, -K309}, '{K851, K526, KZ}, '{K717, K682, K148}, '{K717, K682, -K148},
    '{K526, K851, KZ}, '{K425, K688, K588}, '{K864, K443, K239}, '{K688, K588, K425},
    '{K809, K309, K500}, '{K682, K148, K717}, '{K588, K425, K688}, '{K955, K295, KZ},
    '{K1000, KZ, KZ}, '{K951, K162, K263}, '{K851, -K526, KZ}, '{K955, -K295, KZ},
    '{K864, -K443, K239}, '{K951, -K162, K263}, '{K809, -K309, K500}, '{K682, -K148, K717},
    '{K851, KZ, K526}, '{K864, K443, -K239}, '{K809, K309, -K500}, '{K951, K162, -K263},
    '{K526, KZ, -K851}, '{K682, K148, -K717}, '{K682, -K148, -K717}, '{K851, KZ, -K526},
    '{K809, -K309, -K500}, '{K864, -K443, -K239}, '{K951, -K162, -K263}, '{K148, K717, -K682},
    '{K309, K500, -K809}, '{K425, K688, -K588}, '{K443, K239, -K864}, '{K588, K425, -K688},
    '{K688, K588, -K425}, '{-K148, K717, -K682}, '{-K309, K500, -K809}, '{KZ, K526, -K851},
    '{-K526, KZ, -K851}, '{-K443, K239, -K864}, '{-K295, KZ, -K955}, '{-K162, K263, -K951},
    '{KZ, KZ, -K1000}, '{K295, KZ, -K955}, '{K162, K263, -K951}, '{-K443, -K239, -K864},
    '{-K309, -K500, -K809}, '{-K162, -K263, -K951}, '{KZ, -K851, -K526}, '{-K148, -K717, -K682},
    '{K148, -K717, -K682}, '{KZ, -K526, -K851}, '{K309, -K500, -K809}, '{K443, -K239, -K864},
    '{K162, -K263, -K951}, '{K239, -K864, -K443}, '{K500, -K809, -K309}, '{K425, -K688, -K588},
    '{K717, -K682, -K148}, '{K688, -K588, -K425}, '{K588, -K425, -K688}, '{KZ, -K955, -K295},
    '{KZ, -K1000, KZ}, '{K263, -K951, -K162}, '{KZ, -K851, K526}, '{KZ, -K955, K295},
    '{K239, -K864, K443}, '{K263, -K951, K162}, '{K500, -K809, K309}, '{K717, -K682, K148},
    '{K526, -K851, KZ}, '{-K239, -K864, -K443}, '{-K500, -K809, -K309}, '{-K263, -K951, -K162},
    '{-K851, -K526, KZ}, '{-K717, -K682, -K148}, '{-K717, -K682, K148}, '{-K526, -K851, KZ},
    '{-K500, -K809, K309}, '{-K239, -K864, K443}, '{-K263, -K951, K162}, '{-K864, -K443, K239},
    '{-K809, -K309, K500}, '{-K688, -K588, K425}, '{-K682, -K148, K717}, '{-K443, -K239, K864},
    '{-K588, -K425, K688}, '{-K309, -K500, K809}, '{-K148, -K717, K682}, '{-K425, -K688, K588},
    '{-K162, -K263, K951}, '{K443, -K239, K864}, '{K162, -K263, K951}, '{K309, -K500, K809},
    '{K148, -K717, K682}, '{KZ, -K526, K851}, '{K425, -K688, K588}, '{K588, -K425, K688},
    '{K688, -K588, K425}, '{-K955, K295, KZ}, '{-K951, K162, K263}, '{-K1000, KZ, KZ},
    '{-K851, KZ, K526}, '{-K955, -K295, KZ}, '{-K951, -K162, K263}, '{-K864, K443, -K239},
    '{-K951, K162, -K263}, '{-K809, K309, -K500}, '{-K864, -K443, -K239}, '{-K951, -K162, -K263},
    '{-K809, -K309, -K500}, '{-K682, K148, -K717}, '{-K682, -K148, -K717}, '{-K851, KZ, -K526},
    '{-K688, K588, -K425}, '{-K588, K425, -K688}, '{-K425, K688, -K588}, '{-K425, -K688, -K588},
    '{-K588, -K425, -K688}, '{-K688, -K588, -K425}
  };

endpackage

// ===== rtl/core/nvq_dot.sv =====
// ----------------------------------------------------------------------------
// nvq_dot
// Two-stage dot product of the input vector with every table normal.
// Stage A: three products per normal. Stage B: their sum.
// ----------------------------------------------------------------------------
module nvq_dot
  import nvq_pkg::*;
#(
  parameter int COUNT     = 162,
  parameter int FRAC_BITS = 14,
  parameter int DOT_W     = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  dir_t                    dir_x,
  input  dir_t                    dir_y,
  input  dir_t                    dir_z,
  output logic                    out_vld,
  output logic signed [DOT_W-1:0] dot [COUNT]
);

  localparam int PROD_W = DOT_W - 2;

  // coefficient rescaled from Q1.14, rounding half up
  function automatic logic signed [DOT_W-1:0] coef(input rom_t q);
    logic signed [DOT_W+15:0] s;
    s = (DOT_W+16)'(q) <<< FRAC_BITS;
    s = s + (DOT_W+16)'(8192);
    return DOT_W'(s >>> ROM_FRAC);
  endfunction

  logic                     vld_a_r;
  logic signed [PROD_W-1:0] px_r [COUNT];
  logic signed [PROD_W-1:0] py_r [COUNT];
  logic signed [PROD_W-1:0] pz_r [COUNT];
  logic                     vld_b_r;
  logic signed [DOT_W-1:0]  dot_r [COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < COUNT; j++) begin
        px_r[j]  <= PROD_W'(DOT_W'(dir_x) * coef(NORMAL_ROM[j][0]));
        py_r[j]  <= PROD_W'(DOT_W'(dir_y) * coef(NORMAL_ROM[j][1]));
        pz_r[j]  <= PROD_W'(DOT_W'(dir_z) * coef(NORMAL_ROM[j][2]));
        dot_r[j] <= DOT_W'(px_r[j]) + DOT_W'(py_r[j]) + DOT_W'(pz_r[j]);
      end
    end
  end

  assign out_vld = vld_b_r;
  assign dot     = dot_r;

endmodule

// ===== rtl/core/nvq_argmax.sv =====
// ----------------------------------------------------------------------------
// nvq_argmax
// Registered pairwise max tree; lower index wins ties.
// ----------------------------------------------------------------------------
module nvq_argmax
  import nvq_pkg::*;
#(
  parameter int COUNT = 162,
  parameter int DOT_W = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  logic signed [DOT_W-1:0] dot [COUNT],
  output logic                    out_vld,
  output idx_t                    idx
);

  localparam int LVLS = (COUNT > 1) ? $clog2(COUNT) : 1;
  localparam int W    = 1 << LVLS;

  // level l occupies W >> l nodes; padding nodes are marked absent
  logic signed [DOT_W-1:0] val_r [1:LVLS][W];
  idx_t                    ix_r  [1:LVLS][W];
  logic                    has_r [1:LVLS][W];
  logic                    vld_r [1:LVLS];

  // inputs of each level: entry 0 is the incoming dot products
  logic signed [DOT_W-1:0] lv_val [LVLS][W];
  idx_t                    lv_ix  [LVLS][W];
  logic                    lv_has [LVLS][W];
  logic                    lv_vld [LVLS];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      lv_val[0][i] = (i < COUNT) ? dot[i] : '0;
      lv_ix[0][i]  = IDX_W'(i);
      lv_has[0][i] = (i < COUNT);
    end
    lv_vld[0] = in_vld;
    for (int l = 1; l < LVLS; l++) begin
      for (int i = 0; i < W; i++) begin
        lv_val[l][i] = val_r[l][i];
        lv_ix[l][i]  = ix_r[l][i];
        lv_has[l][i] = has_r[l][i];
      end
      lv_vld[l] = vld_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 1; l <= LVLS; l++) vld_r[l] <= 1'b0;
    end else if (adv) begin
      for (int l = 1; l <= LVLS; l++) vld_r[l] <= lv_vld[l-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 1; l <= LVLS; l++) begin
        for (int i = 0; i < (W >> l); i++) begin
          if (lv_has[l-1][2*i+1] &&
              (!lv_has[l-1][2*i] || lv_val[l-1][2*i+1] > lv_val[l-1][2*i])) begin
            val_r[l][i] <= lv_val[l-1][2*i+1];
            ix_r[l][i]  <= lv_ix[l-1][2*i+1];
          end else begin
            val_r[l][i] <= lv_val[l-1][2*i];
            ix_r[l][i]  <= lv_ix[l-1][2*i];
          end
          has_r[l][i] <= lv_has[l-1][2*i] | lv_has[l-1][2*i+1];
        end
        for (int i = (W >> l); i < W; i++) begin
          val_r[l][i] <= '0;
          ix_r[l][i]  <= '0;
          has_r[l][i] <= 1'b0;
        end
      end
    end
  end

  assign out_vld = vld_r[LVLS];
  assign idx     = ix_r[LVLS][0];

endmodule

// ===== rtl/core/normal_vector_quantizer_core.sv =====
// ----------------------------------------------------------------------------
// normal_vector_quantizer_core
// Nearest-normal quantizer: index of the table normal with largest dot product.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one direction vector per transfer, Q1.14 signed components.
//   out_* : one normal index per input vector, in input order.
//   Pipeline: a product stage, a sum stage, one stage per level of the max
//   tree and the output register.
//   Throughput: one vector per cycle; the pipeline runs whenever the output
//   register is empty or being taken.
//   Receiver stall: the whole pipeline holds, nothing lost or repeated.
//   Reset: all valid bits clear, no result pending.
//   Ties go to the lowest index; a zero vector gives index 0.
// ----------------------------------------------------------------------------
module normal_vector_quantizer_core
  import nvq_pkg::*;
#(
  parameter int NORMAL_COUNT  = 162,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // normal_index[7:0]
);

  localparam int COUNT = (NORMAL_COUNT < ROM_SIZE) ? NORMAL_COUNT : ROM_SIZE;
  localparam int DOT_W = 16 + FRACTION_BITS + 4;

  logic                    adv;
  logic                    dot_vld;
  logic signed [DOT_W-1:0] dot [COUNT];
  logic                    am_vld;
  idx_t                    am_idx;
  logic                    out_vld_r;
  idx_t                    out_idx_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  nvq_dot #(.COUNT(COUNT), .FRAC_BITS(FRACTION_BITS), .DOT_W(DOT_W)) u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .dir_x   (dir_t'(in_tdata[15:0])),
    .dir_y   (dir_t'(in_tdata[31:16])),
    .dir_z   (dir_t'(in_tdata[47:32])),
    .out_vld (dot_vld),
    .dot     (dot)
  );

  nvq_argmax #(.COUNT(COUNT), .DOT_W(DOT_W)) u_argmax (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (dot_vld),
    .dot     (dot),
    .out_vld (am_vld),
    .idx     (am_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= am_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_idx_r <= am_idx;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_idx_r;

endmodule

// ===== tb/sv/nvq_checker.sv =====
// ----------------------------------------------------------------------------
// nvq_checker
// Watches both stream channels, predicts the nearest normal for every input
// transfer and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module nvq_checker
  import nvq_pkg::*;
#(
  parameter int NORMAL_COUNT  = 162,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  idx_t index_queue[$];

  function automatic longint scale_coef(rom_t q);
    longint s;
    s = longint'(q) * (longint'(1) << FRACTION_BITS) + 8192;
    return s >>> 14;
  endfunction

  function automatic idx_t nearest_normal(dir_t dx, dir_t dy, dir_t dz);
    longint best;
    longint dot;
    int     lim;
    idx_t   win;
    best = 0;
    win  = '0;
    lim  = (NORMAL_COUNT < ROM_SIZE) ? NORMAL_COUNT : ROM_SIZE;
    for (int j = 0; j < lim; j++) begin
      dot = longint'(dx) * scale_coef(NORMAL_ROM[j][0])
          + longint'(dy) * scale_coef(NORMAL_ROM[j][1])
          + longint'(dz) * scale_coef(NORMAL_ROM[j][2]);
      // strict compare: lowest index keeps a tie
      if (j == 0 || dot > best) begin
        best = dot;
        win  = idx_t'(j);
      end
    end
    return win;
  endfunction

  assign pending_count = index_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    idx_t want;
    if (rst_n && in_tvalid && in_tready)
      index_queue.push_back(nearest_normal(dir_t'(in_tdata[15:0]),
                                           dir_t'(in_tdata[31:16]),
                                           dir_t'(in_tdata[47:32])));
    if (rst_n && out_tvalid && out_tready) begin
      if (index_queue.size() == 0) begin
        $display("%t: unexpected result, actual normal_index %0d", $realtime, out_tdata);
        fail_count++;
      end else begin
        want = index_queue.pop_front();
        if (out_tdata !== want) begin
          $display("%t: normal_index mismatch, expected %0d actual %0d",
                   $realtime, want, out_tdata);
          fail_count++;
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random direction vectors with random gaps and output
// back-pressure, including one long output stall; a checker judges results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_VECTORS = 1500;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  int          fail_count;
  int          pending_count;
  int          idle_cycles;
  bit          hold_off;

  normal_vector_quantizer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  nvq_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one vector transfer; gap drawn per item, valid stays up when there is none
  task automatic send_vector(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dz, dy, dx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall per result, one long hold-off mid-run
  initial begin
    int wait_n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    idle_cycles = 0;
    hold_off    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero vector, axes, extremes, ties between neighbors
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h4000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h4000, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h4000);
    send_vector(16'hc000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'hc000, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'hc000);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h7fff, 16'h0000);
    send_vector(16'h7fff, 16'h8000, 16'h8000);
    send_vector(16'hffff, 16'hffff, 16'hffff);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0001, 16'h0001);
    send_vector(16'h5555, 16'haaaa, 16'h5555);
    send_vector(16'haaaa, 16'h5555, 16'haaaa);
    send_vector(16'h2000, 16'h2000, 16'h0000);
    send_vector(16'h0000, 16'h2000, 16'he000);

    n = 0;
    fork
      begin
        while (n < RANDOM_VECTORS) begin
          if (n == RANDOM_VECTORS / 2) hold_off = 1'b1;
          send_vector(rand_comp(), rand_comp(), rand_comp());
          n++;
        end
      end
    join
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nvq_pkg.sv
rtl/core/nvq_dot.sv
rtl/core/nvq_argmax.sv
rtl/core/normal_vector_quantizer_core.sv
tb/sv/nvq_checker.sv
tb/sv/tb_top.sv
